[design/khd_pkg.sv]
// Shared types, constants and helpers for the k-mer histogram distance block.
// No dependencies; imported by every module of the block.
package khd_pkg;

  localparam int IN_BITS       = 16;   // width of the count ports
  localparam int COUNT_BITS    = 16;   // significant count bits
  localparam int ACC_BITS      = 28;   // accumulator width
  localparam int FRAC_BITS     = 17;   // Q0.16 result incl. the 1.0 code
  localparam int LOG_FRAC_BITS = 20;   // fraction bits of the log2 result
  localparam int LOG_INT_BITS  = 2;    // integer part of log2(1+10F) is 0..3
  localparam int LOG_BITS      = LOG_INT_BITS + LOG_FRAC_BITS;
  localparam int INV_BITS      = 23;
  localparam int PROD_BITS     = LOG_BITS + INV_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam int MASK_BITS = (COUNT_BITS < IN_BITS) ? COUNT_BITS : IN_BITS;
  localparam logic [IN_BITS-1:0] COUNT_MASK = IN_BITS'((33'd1 << MASK_BITS) - 33'd1);

  localparam logic [FRAC_BITS-1:0] ONE_Q16         = 17'd65536;
  localparam logic [INV_BITS-1:0]  INV_LOG2_11_Q24 = 23'd4849703;  // 1/log2(11)
  localparam logic [ACC_BITS-1:0]  ACC_MAX         = '1;

  // One finished histogram pair handed from the front to the back.
  typedef struct packed {
    logic [ACC_BITS-1:0] minima;
    logic [ACC_BITS-1:0] denom;
  } job_t;

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] acc,
                                                  input logic [IN_BITS-1:0]  v);
    logic [ACC_BITS:0] s;
    s = {1'b0, acc} + (ACC_BITS+1)'(v);
    return s[ACC_BITS] ? ACC_MAX : s[ACC_BITS-1:0];
  endfunction

endpackage

[design/khd_front.sv]
// Front end: takes bin pairs, keeps the minima sum and both totals, and on
// the last bin emits one job (minima sum, chosen denominator). Uses khd_pkg.
module khd_front import khd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [0:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [IN_BITS-1:0] count_first,
  input  logic [IN_BITS-1:0] count_second,
  input  logic               last_bin,
  output logic               push,
  output job_t               job
);

  logic                mode;
  logic [ACC_BITS-1:0] minima_sum, total_first, total_second;
  logic [ACC_BITS-1:0] minima_sum_next, total_first_next, total_second_next;
  logic [IN_BITS-1:0]  a, b, mn;
  logic                accept;

  always_comb begin
    a = count_first & COUNT_MASK;
    b = count_second & COUNT_MASK;
    mn = (a < b) ? a : b;
    minima_sum_next   = sat_add(minima_sum, mn);
    total_first_next  = sat_add(total_first, a);
    total_second_next = sat_add(total_second, b);
    job.minima = minima_sum_next;
    if (mode) begin
      job.denom = (total_first_next > total_second_next) ? total_first_next
                                                         : total_second_next;
    end else begin
      job.denom = (total_first_next < total_second_next) ? total_first_next
                                                         : total_second_next;
    end
  end

  assign accept = in_valid & in_ready;
  assign push   = accept & last_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      minima_sum   <= '0;
      total_first  <= '0;
      total_second <= '0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data[0];
      end
      if (accept) begin
        if (last_bin) begin
          minima_sum   <= '0;
          total_first  <= '0;
          total_second <= '0;
        end else begin
          minima_sum   <= minima_sum_next;
          total_first  <= total_first_next;
          total_second <= total_second_next;
        end
      end
    end
  end

endmodule

[design/khd_queue.sv]
// Short job queue between the accumulating front and the arithmetic back.
// Uses khd_pkg for job_t and the depth constants.
module khd_queue import khd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("job queue count out of range");

endmodule

[design/khd_back.sv]
// Back end: per nonempty job a bit-serial restoring divide, a normalize step,
// a squaring log2 loop, a constant scale and the output register. Uses khd_pkg.
module khd_back import khd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  job_t                 head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS-1:0] distance,
  output logic [FRAC_BITS-1:0] shared_fraction,
  output logic                 empty_flag
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_NORM  = 6'b000100,
    S_LOG   = 6'b001000,
    S_SCALE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                    state;
  logic [4:0]                cnt;
  logic [ACC_BITS-1:0]       den, rem;
  logic [FRAC_BITS-1:0]      num_lo;   // low numerator bits, fed MSB first
  logic [FRAC_BITS-1:0]      quo;
  logic                      is_empty;
  logic [1:0]                expo;
  logic [30:0]               mant;     // Q30, in [1, 2)
  logic [LOG_FRAC_BITS-1:0]  log_frac;
  logic [PROD_BITS-1:0]      prod;

  logic [ACC_BITS+FRAC_BITS-1:0] numer;
  logic [ACC_BITS:0]         rem_sh;
  logic                      fits;
  logic [FRAC_BITS-1:0]      frac_c;
  logic [19:0]               y;
  logic [1:0]                e_c;
  logic [33:0]               y_sh;
  logic [61:0]               sq;
  logic [31:0]               msq;
  logic [PROD_BITS:0]        rounded;
  logic [17:0]               t;
  logic [FRAC_BITS-1:0]      dist_c;
  logic                      load_out;

  always_comb begin
    // numerator = minima * 2^16 + denom / 2
    numer  = {1'b0, head.minima, 16'd0} + (ACC_BITS+FRAC_BITS)'(head.denom >> 1);
    rem_sh = {rem, num_lo[FRAC_BITS-1]};
    fits   = (rem_sh >= {1'b0, den});

    frac_c = (quo > ONE_Q16) ? ONE_Q16 : quo;
    y      = 20'd65536 + {frac_c, 3'd0} + {2'd0, frac_c, 1'b0};
    if (y[19]) begin
      e_c = 2'd3;
    end else if (y[18]) begin
      e_c = 2'd2;
    end else if (y[17]) begin
      e_c = 2'd1;
    end else begin
      e_c = 2'd0;
    end
    y_sh = {y, 14'd0} >> e_c;

    sq  = mant * mant;
    msq = sq[61:30];

    rounded = {1'b0, prod} + (PROD_BITS+1)'(28'd1 << 27);
    t       = rounded[PROD_BITS:28];
    dist_c  = (t > {1'b0, ONE_Q16}) ? '0 : FRAC_BITS'({1'b0, ONE_Q16} - t);
  end

  assign pop      = (state == S_IDLE) && !empty;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (!empty) state <= (head.denom == '0) ? S_DONE : S_DIV;
        S_DIV:   if (cnt == '0) state <= S_NORM;
        S_NORM:  state <= S_LOG;
        S_LOG:   if (cnt == '0) state <= S_SCALE;
        S_SCALE: state <= S_DONE;
        S_DONE:  if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        den      <= head.denom;
        rem      <= numer[ACC_BITS+FRAC_BITS-1:FRAC_BITS];
        num_lo   <= numer[FRAC_BITS-1:0];
        quo      <= '0;
        is_empty <= (head.denom == '0);
        cnt      <= 5'(FRAC_BITS - 1);
      end
      S_DIV: begin
        rem    <= fits ? ACC_BITS'(rem_sh - {1'b0, den}) : rem_sh[ACC_BITS-1:0];
        quo    <= {quo[FRAC_BITS-2:0], fits};
        num_lo <= {num_lo[FRAC_BITS-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
      end
      S_NORM: begin
        quo      <= frac_c;
        expo     <= e_c;
        mant     <= y_sh[30:0];
        log_frac <= '0;
        cnt      <= 5'(LOG_FRAC_BITS - 1);
      end
      S_LOG: begin
        // square; a result of 2 or more gives a one bit and halves back
        mant     <= msq[31] ? msq[31:1] : msq[30:0];
        log_frac <= {log_frac[LOG_FRAC_BITS-2:0], msq[31]};
        cnt      <= cnt - 1'b1;
      end
      S_SCALE: begin
        prod <= PROD_BITS'({expo, log_frac}) * PROD_BITS'(INV_LOG2_11_Q24);
      end
      S_DONE: begin
        if (load_out) begin
          distance        <= is_empty ? '0 : dist_c;
          shared_fraction <= is_empty ? '0 : quo;
          empty_flag      <= is_empty;
        end
      end
      default: begin
      end
    endcase
  end

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_flag) |-> (distance == '0 && shared_fraction == '0))
    else $error("empty result carries nonzero fields");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (shared_fraction <= ONE_Q16 && distance <= ONE_Q16))
    else $error("result above 1.0");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0 && rem < den))
    else $error("divider remainder out of range");
  a_norm_mant: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOG) |-> mant[30])
    else $error("log mantissa not normalized");

endmodule

[design/kmer_histogram_distance.sv]
// Top level of the k-mer histogram distance block.
// Instantiates khd_front, khd_queue and khd_back; uses khd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle: a pair of
//   bin counts and last_bin. Totals and the minima sum build up in the front;
//   the word with last_bin set closes the histogram pair and queues one job.
//   Output channel (out_valid/out_ready) gives one word per pair: distance
//   and shared_fraction in Q0.16 (65536 = 1.0) and empty_flag, set with both
//   values 0 when the chosen total is zero.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   denominator_mode: 0 divides by the smaller total, 1 by the larger. Write
//   it only while no pair is in flight.
// Timing:
//   Bins stream at one per cycle while in_ready is high. Per pair the back unit
//   runs the pop cycle, the bit-serial divider, a normalize step, the squaring
//   log2 loop, a scale multiply and the output load; an empty pair goes from
//   the pop straight to the output load. Two jobs can queue; with pairs shorter
//   than one back pass in_ready drops until the back catches up. A stalled
//   output holds its word and backs up the same way.
// Reset: sums, mode, queue and output valid are cleared; no clearing pass.
module kmer_histogram_distance import khd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_BITS-1:0]   count_first,
  input  logic [IN_BITS-1:0]   count_second,
  input  logic                 last_bin,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS-1:0] distance,
  output logic [FRAC_BITS-1:0] shared_fraction,
  output logic                 empty_flag
);

  logic push, pop, q_full, q_empty;
  job_t push_job, head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  khd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .count_first  (count_first),
    .count_second (count_second),
    .last_bin     (last_bin),
    .push         (push),
    .job          (push_job)
  );

  khd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  khd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .distance        (distance),
    .shared_fraction (shared_fraction),
    .empty_flag      (empty_flag)
  );

endmodule

[test/tb_kmer_histogram_distance.sv]
// Self-checking testbench for kmer_histogram_distance: streams histogram pairs
// through the valid/ready input, checks each distance word against a local model.
// Depends on khd_pkg and kmer_histogram_distance only.
module tb_kmer_histogram_distance;
  import khd_pkg::*;

  localparam logic MODE_SMALLER = 1'b0;   // divide by the smaller total
  localparam logic MODE_LARGER  = 1'b1;   // divide by the larger total

  localparam longint unsigned UNIT      = 64'd65536;    // 1.0 in Q16
  localparam longint unsigned INV_LOG11 = 64'd4849703;  // 1/log2(11) in Q24
  localparam longint unsigned ACC_LIMIT = (64'd1 << ACC_BITS) - 1;
  localparam int BACK_LATENCY = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [FRAC_BITS-1:0] distance;
    logic [FRAC_BITS-1:0] fraction;
    logic                 empty;
  } pair_result_t;

  typedef struct packed {
    logic                mode;
    logic [IN_BITS-1:0]  a;
    logic [IN_BITS-1:0]  b;
    logic                last;
    logic                typed;   // want holds a hand-written result
    pair_result_t        want;
  } bin_row_t;

  localparam pair_result_t NO_RESULT  = '{17'd0, 17'd0, 1'b0};
  localparam pair_result_t EMPTY_PAIR = '{17'd0, 17'd0, 1'b1};
  localparam pair_result_t DISJOINT   = '{17'd65536, 17'd0, 1'b0};  // F = 0, D = 1.0

  localparam int NUM_ROWS = 20;
  localparam bin_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{MODE_SMALLER, 16'd0,     16'd0,     1'b1, 1'b1, EMPTY_PAIR},
    '{MODE_SMALLER, 16'hFFFF,  16'd0,     1'b1, 1'b1, EMPTY_PAIR},
    '{MODE_SMALLER, 16'hFFFF,  16'hFFFF,  1'b1, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd100,   16'd50,    1'b0, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd50,    16'd100,   1'b0, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd0,     16'd0,     1'b0, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd300,   16'd200,   1'b1, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'hFFFF,  16'd1,     1'b1, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd1,     16'hFFFF,  1'b1, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd40000, 16'd20000, 1'b0, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'hAAAA,  16'h5555,  1'b1, 1'b0, NO_RESULT},
    '{MODE_LARGER,  16'd0,     16'd0,     1'b1, 1'b1, EMPTY_PAIR},
    '{MODE_LARGER,  16'hFFFF,  16'd0,     1'b1, 1'b1, DISJOINT},
    '{MODE_LARGER,  16'd0,     16'hFFFF,  1'b1, 1'b1, DISJOINT},
    '{MODE_LARGER,  16'hFFFF,  16'hFFFF,  1'b1, 1'b0, NO_RESULT},
    '{MODE_LARGER,  16'hFFFF,  16'h8000,  1'b1, 1'b0, NO_RESULT},
    '{MODE_LARGER,  16'd1,     16'd0,     1'b0, 1'b0, NO_RESULT},
    '{MODE_LARGER,  16'd0,     16'd0,     1'b1, 1'b1, DISJOINT},
    '{MODE_LARGER,  16'h5555,  16'hAAAA,  1'b1, 1'b0, NO_RESULT},
    '{MODE_SMALLER, 16'd12345, 16'd54321, 1'b1, 1'b0, NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [0:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [IN_BITS-1:0]   count_first;
  logic [IN_BITS-1:0]   count_second;
  logic                 last_bin;
  logic                 out_valid;
  logic                 out_ready;
  logic [FRAC_BITS-1:0] distance;
  logic [FRAC_BITS-1:0] shared_fraction;
  logic                 empty_flag;

  // model state
  logic [ACC_BITS-1:0] sum_min;
  logic [ACC_BITS-1:0] sum_first;
  logic [ACC_BITS-1:0] sum_second;
  logic                model_mode;

  pair_result_t pending_results[$];
  int  failures = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;
  bit  hold_output = 1'b0;

  kmer_histogram_distance dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .count_first     (count_first),
    .count_second    (count_second),
    .last_bin        (last_bin),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .distance        (distance),
    .shared_fraction (shared_fraction),
    .empty_flag      (empty_flag)
  );

  always #5 clk = ~clk;

  function automatic logic [ACC_BITS-1:0] acc_add(input logic [ACC_BITS-1:0] acc,
                                                  input logic [IN_BITS-1:0]  v);
    longint unsigned s;
    s = 64'(acc) + 64'(v);
    if (s > ACC_LIMIT) s = ACC_LIMIT;
    return s[ACC_BITS-1:0];
  endfunction

  // log2(y/65536) in Q20, y in [1.0, 11.0] as Q16; bit-serial squaring
  function automatic longint unsigned log2_fixed(input longint unsigned y);
    int unsigned     e;
    int              i;
    longint unsigned m;
    longint unsigned res;
    e = 0;
    while (e < 4 && (y >> e) >= 2 * UNIT) e++;
    m = (y << 14) >> e;
    res = 64'(e) << LOG_FRAC_BITS;
    for (i = LOG_FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res = res | (64'd1 << i);
      end
    end
    return res;
  endfunction

  function automatic pair_result_t pair_distance(input logic [ACC_BITS-1:0] minima,
                                                 input logic [ACC_BITS-1:0] first_total,
                                                 input logic [ACC_BITS-1:0] second_total,
                                                 input logic                mode);
    longint unsigned denom;
    longint unsigned frac;
    longint unsigned t;
    pair_result_t    r;
    if (mode == MODE_SMALLER)
      denom = (first_total < second_total) ? 64'(first_total) : 64'(second_total);
    else
      denom = (first_total > second_total) ? 64'(first_total) : 64'(second_total);
    r = NO_RESULT;
    if (denom == 0) begin
      r = EMPTY_PAIR;
    end else begin
      frac = (64'(minima) * UNIT + denom / 2) / denom;
      if (frac > UNIT) frac = UNIT;
      t = (log2_fixed(UNIT + 10 * frac) * INV_LOG11 + (64'd1 << 27)) >> 28;
      r.distance = (t > UNIT) ? '0 : FRAC_BITS'(UNIT - t);
      r.fraction = FRAC_BITS'(frac);
    end
    return r;
  endfunction

  // fold one accepted bin into the sums; a closing bin queues its result
  task automatic fold_bin(input logic [IN_BITS-1:0] a, input logic [IN_BITS-1:0] b,
                          input logic last);
    sum_min    = acc_add(sum_min, (a < b) ? a : b);
    sum_first  = acc_add(sum_first, a);
    sum_second = acc_add(sum_second, b);
    if (last) begin
      pending_results.push_back(pair_distance(sum_min, sum_first, sum_second, model_mode));
      sum_min    = '0;
      sum_first  = '0;
      sum_second = '0;
    end
  endtask

  task automatic send_bin(input logic [IN_BITS-1:0] a, input logic [IN_BITS-1:0] b,
                          input logic last);
    int gap;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    count_first  <= a;
    count_second <= b;
    last_bin     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_bin(a, b, last);
  endtask

  // stop offering words and let every pair in flight come out
  task automatic drain_pairs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (BACK_LATENCY) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain_pairs();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic draw_counts(input int style, output logic [IN_BITS-1:0] a,
                             output logic [IN_BITS-1:0] b);
    a = $urandom_range(0, 65535);
    b = $urandom_range(0, 65535);
    case (style)
      1: b = a;
      2: begin
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
      end
      3: begin
        if ($urandom_range(0, 1)) a = '0;
        else b = '0;
      end
      4: b = a ^ IN_BITS'($urandom_range(0, 255));
      5: begin
        a = '0;
        b = '0;
      end
      default: ;
    endcase
  endtask

  // output side: random ready gaps, one long hold-off on request
  initial begin
    int           gap;
    pair_result_t want;
    wait (rst == 1'b0);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = out_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected word: dist %0d frac %0d empty %0d",
                   distance, shared_fraction, empty_flag);
      end else begin
        want = pending_results.pop_front();
        if (distance !== want.distance || shared_fraction !== want.fraction ||
            empty_flag !== want.empty) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("mismatch: expected dist %0d frac %0d empty %0d, got %0d %0d %0d",
                     want.distance, want.fraction, want.empty,
                     distance, shared_fraction, empty_flag);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int                 i;
    int                 phase;
    int                 sent;
    int                 len;
    int                 pick;
    int                 style;
    int                 k;
    logic [IN_BITS-1:0] a;
    logic [IN_BITS-1:0] b;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    count_first  = '0;
    count_second = '0;
    last_bin     = 1'b0;
    out_ready    = 1'b0;
    sum_min      = '0;
    sum_first    = '0;
    sum_second   = '0;
    model_mode   = MODE_SMALLER;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows; the first ones rely on the reset value of the mode
    for (i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].mode != model_mode) write_mode(DIRECTED_ROWS[i].mode);
      send_bin(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].last);
      if (DIRECTED_ROWS[i].typed)
        pending_results[pending_results.size() - 1] = DIRECTED_ROWS[i].want;
    end

    for (phase = 0; phase < 6; phase++) begin
      in_idle  = (phase != 2);
      out_idle = (phase != 2);
      write_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
      if (phase == 3) hold_output = 1'b1;
      sent = 0;
      while (sent < 270) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      len = $urandom_range(1, 6);
        else if (pick < 9) len = $urandom_range(7, 40);
        else               len = $urandom_range(41, 120);
        style = $urandom_range(0, 5);
        for (k = 0; k < len; k++) begin
          draw_counts(style, a, b);
          send_bin(a, b, k == len - 1);
        end
        sent += len;
      end
    end

    drain_pairs();
    failures += pending_results.size();
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
